FILE: rtl/udiv_pkg.sv
package udiv_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned STEPS  = 32;
  localparam int unsigned CNT_W  = 5;

  localparam logic [WORD_W-1:0] QUOT_ALL_ONES = 32'hFFFF_FFFF;

  // one classified division job
  typedef struct packed {
    logic [2*WORD_W-1:0] dividend;
    logic [WORD_W-1:0]   divisor;
    logic                saturated;
  } udiv_job_t;

endpackage

FILE: rtl/udiv_front.sv
module udiv_front import udiv_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [95:0]     in_tdata,
  output logic            job_valid,
  input  logic            job_ready,
  output udiv_job_t       job
);

  logic      hold_valid_r, hold_valid_nxt;
  udiv_job_t hold_r;
  logic      accept;

  assign in_tready = !hold_valid_r || job_ready;
  assign accept    = in_tvalid && in_tready;
  assign job_valid = hold_valid_r;
  assign job       = hold_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (job_ready) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  // overflow when the high half is not below the divisor (covers zero divisor)
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r.dividend  <= in_tdata[63:0];
      hold_r.divisor   <= in_tdata[95:64];
      hold_r.saturated <= (in_tdata[63:32] >= in_tdata[95:64]);
    end
  end

endmodule

FILE: rtl/udiv_queue.sv
module udiv_queue import udiv_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  udiv_job_t push_job,
  output logic      pop_valid,
  input  logic      pop_ready,
  output udiv_job_t pop_job
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W_Q = $clog2(DEPTH + 1);

  udiv_job_t          mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W_Q-1:0] count_r, count_nxt;
  logic               push, pop;

  assign push_ready = (count_r != CNT_W_Q'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W_Q'(DEPTH))
    else $error("queue fill count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) || (count_r == CNT_W_Q'(DEPTH)) |-> wr_ptr_r == rd_ptr_r)
    else $error("queue pointers disagree with fill count");

endmodule

FILE: rtl/udiv_core.sv
module udiv_core import udiv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  udiv_job_t         job,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [WORD_W-1:0] out_tdata,
  output logic              out_tuser
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [2*WORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0]   divisor_r, divisor_nxt;
  logic                sat_r, sat_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]   out_quot_r;
  logic                out_sat_r;
  logic                out_free, finish;
  logic [WORD_W:0]     trial;
  logic [WORD_W:0]     diff;
  logic                qbit;

  assign out_free  = !out_valid_r || out_tready;
  assign job_ready = (state_r == ST_IDLE);
  assign finish    = (state_r == ST_DONE) && out_free;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {acc_r[2*WORD_W-1:WORD_W], acc_r[WORD_W-1]};
  assign diff  = trial - {1'b0, divisor_r};
  assign qbit  = !diff[WORD_W];

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    acc_nxt     = acc_r;
    divisor_nxt = divisor_r;
    sat_nxt     = sat_r;
    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          divisor_nxt = job.divisor;
          sat_nxt     = job.saturated;
          count_nxt   = '0;
          if (job.saturated) begin
            acc_nxt   = {job.dividend[2*WORD_W-1:WORD_W], QUOT_ALL_ONES};
            state_nxt = ST_DONE;
          end else begin
            acc_nxt   = job.dividend;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        acc_nxt = {(qbit ? diff[WORD_W-1:0] : trial[WORD_W-1:0]),
                   acc_r[WORD_W-2:0], qbit};
        count_nxt = count_r + 1'b1;
        if (count_r == CNT_W'(STEPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    divisor_r <= divisor_nxt;
    sat_r     <= sat_nxt;
    if (finish) begin
      out_quot_r <= acc_r[WORD_W-1:0];
      out_sat_r  <= sat_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_quot_r;
  assign out_tuser  = out_sat_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> acc_r[2*WORD_W-1:WORD_W] < divisor_r)
    else $error("partial remainder not below divisor");

  a_sat_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_sat_r |-> out_quot_r == QUOT_ALL_ONES)
    else $error("saturated result without all-ones quotient");

  a_run_leaves_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && $past(state_r) == ST_RUN |-> count_r == '0)
    else $error("iteration count wrong at end of division");

endmodule

FILE: rtl/unsigned_divide_64_by_32_unit.sv
// channel  | dir | tdata (low bit up)                  | tuser
// ---------+-----+-------------------------------------+-----------
// in_      | in  | dividend[63:0], divisor[95:64]      | -
// out_     | out | quotient[31:0]                      | saturated
//
// an unsaturated division passes from the input transaction through the
// front register, the queue, the core load, 32 restoring steps (one
// quotient bit per cycle in the shared subtractor) and the result
// register; saturated jobs skip the 32 steps
// the bit-serial core takes a new job only after its result is registered
// reset (rst_n low, synchronous) empties the front register, queue and core
// either side may stall on its own: the front and queue keep taking
// transactions while the core works or a result waits on out_tready
module unsigned_divide_64_by_32_unit import udiv_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // dividend[63:0], divisor[95:64]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // quotient[31:0]
  output logic        out_tuser   // saturated
);

  // front register to queue
  logic      front_valid;
  logic      front_ready;
  udiv_job_t front_job;

  // queue to divider core
  logic      core_valid;
  logic      core_ready;
  udiv_job_t core_job;

  // accepts transactions and flags quotient overflow up front
  udiv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .job       (front_job)
  );

  // short queue decoupling classification from the iterative core
  udiv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_job   (front_job),
    .pop_valid  (core_valid),
    .pop_ready  (core_ready),
    .pop_job    (core_job)
  );

  // radix-2 restoring divider with registered result
  udiv_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (core_valid),
    .job_ready  (core_ready),
    .job        (core_job),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: sim/unsigned_divide_64_by_32_unit_tb.sv
module unsigned_divide_64_by_32_unit_tb;
  import udiv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // no transaction on either side for this many cycles ends the run
  localparam int unsigned STALL_LIMIT = 4000;
  // long receiver hold-off used to fill the front register and queue
  localparam int unsigned HOLD_CYCLES = 400;
  // settle time after the last result, a little over one full division
  localparam int unsigned TAIL_CYCLES = 50;
  localparam int unsigned MAX_REPORTS = 10;

  // one expected result: the out_ channel's fields
  typedef struct packed {
    logic [31:0] quotient;
    logic        saturated;
  } division_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [95:0] in_tdata;   // dividend[63:0], divisor[95:64]
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // quotient[31:0]
  logic        out_tuser;  // saturated

  division_result_t expected_quotients[$];
  int unsigned      error_count;
  bit               idle_enable;   // random gaps on both sides
  bit               hold_request;  // asks the receiver for one long hold-off

  unsigned_divide_64_by_32_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // floor quotient, saturating whenever the high half reaches the divisor;
  // a zero divisor always lands in the saturating branch
  function automatic division_result_t predict_division(input logic [63:0] dividend,
                                                        input logic [31:0] divisor);
    division_result_t res;
    logic [63:0]      wide_q;
    if (dividend[63:32] >= divisor) begin
      res.quotient  = QUOT_ALL_ONES;
      res.saturated = 1'b1;
    end else begin
      wide_q        = dividend / {32'd0, divisor};
      res.quotient  = wide_q[31:0];
      res.saturated = 1'b0;
    end
    return res;
  endfunction

  // operands packed as {divisor, dividend_hi, dividend_lo}
  // mostly in-range quotients with divisors of every width, then the
  // boundary just below overflow, overflow itself and zero divisors
  function automatic logic [95:0] random_operands();
    logic [31:0] dv;
    logic [31:0] hi;
    logic [31:0] lo;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    lo   = $urandom;
    dv   = $urandom >> $urandom_range(0, 31);
    if (pick < 6) begin
      if (dv == '0) begin
        dv = 32'd1;
      end
      hi = $urandom % dv;
    end else if (pick == 6) begin
      if (dv == '0) begin
        dv = 32'd1;
      end
      hi = dv - 32'd1;
    end else if (pick < 9) begin
      hi = $urandom;
    end else begin
      dv = '0;
      hi = $urandom;
    end
    return {dv, hi, lo};
  endfunction

  // offer one division and wait for its input transaction
  task automatic send_division(input logic [63:0] dividend, input logic [31:0] divisor);
    int unsigned gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {divisor, dividend};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_quotients.push_back(predict_division(dividend, divisor));
  endtask

  // stop offering, then wait until every expected result has arrived
  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (expected_quotients.size() != 0) @(posedge clk);
  endtask

  // extremes, the overflow boundary from both sides and zero divisors
  task automatic test_directed_cases();
    send_division(64'd0, 32'd0);
    send_division(64'hFFFF_FFFF_FFFF_FFFF, 32'd0);
    send_division(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_division(64'hFFFF_FFFE_FFFF_FFFF, 32'hFFFF_FFFF);
    send_division(64'd0, 32'd1);
    send_division(64'd0, 32'hFFFF_FFFF);
    send_division(64'h0000_0000_FFFF_FFFF, 32'd1);
    send_division(64'h0000_0001_0000_0000, 32'd1);
    send_division(64'h7FFF_FFFF_FFFF_FFFF, 32'h8000_0000);
    send_division(64'h8000_0000_0000_0000, 32'h8000_0000);
    send_division(64'h0000_FFFE_FFFF_0000, 32'h0000_FFFF);
    send_division(64'h0000_FFFF_0000_0000, 32'h0000_FFFF);
    send_division(64'hFFFF_0000_0000_0000, 32'hFFFF_0000);
    send_division(64'hFFFE_FFFF_FFFF_FFFF, 32'hFFFF_0000);
    send_division(64'h0000_0000_0000_0007, 32'd7);
    send_division(64'h0000_0000_0000_0006, 32'd7);
    send_division(64'h5555_5555_AAAA_AAAA, 32'hAAAA_AAAA);
    send_division(64'hAAAA_AAAA_5555_5555, 32'h5555_5555);
    wait_for_drain();
  endtask

  task automatic test_random_divisions(input int unsigned count);
    logic [95:0] ops;
    repeat (count) begin
      ops = random_operands();
      send_division(ops[63:0], ops[95:64]);
    end
    wait_for_drain();
  endtask

  // receiver holds off while the sender keeps offering, so in_tready drops
  task automatic test_back_pressure();
    logic [95:0] ops;
    idle_enable  = 1'b0;
    hold_request = 1'b1;
    repeat (12) begin
      ops = random_operands();
      send_division(ops[63:0], ops[95:64]);
    end
    wait_for_drain();
    idle_enable = 1'b1;
  endtask

  // back-to-back stream with no gaps on either side
  task automatic test_steady_stream(input int unsigned count);
    idle_enable = 1'b0;
    test_random_divisions(count);
  endtask

  // receiver: random short gaps, or one long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned sink_gap;
    hold_left  = 0;
    sink_gap   = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        out_tready   <= 1'b0;
      end else if (sink_gap != 0) begin
        out_tready <= 1'b0;
        sink_gap--;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        sink_gap   = $urandom_range(1, 6) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // result checker: each out_ transaction against the oldest expectation
  initial begin
    division_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (expected_quotients.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            $display("unexpected result: quotient %h saturated %b", out_tdata, out_tuser);
          end
        end else begin
          want = expected_quotients.pop_front();
          if (out_tdata !== want.quotient || out_tuser !== want.saturated) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
              $display("mismatch: quotient exp %h got %h, saturated exp %b got %b",
                       want.quotient, out_tdata, want.saturated, out_tuser);
            end
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  initial begin
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    error_count  = 0;
    idle_enable  = 1'b1;
    hold_request = 1'b0;
    rst_n        <= 1'b0;
    in_tvalid    <= 1'b0;
    in_tdata     <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_random_divisions(300);
    test_back_pressure();
    test_steady_stream(90);

    repeat (TAIL_CYCLES) @(posedge clk);
    error_count += expected_quotients.size();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
